/* hdl/rbt_pkg.sv */
`default_nettype none
package rbt_pkg;

   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_QUERY     = 2'd3;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_RD_CUR,      // read node at cur
      OP_STEP,        // compare key, advance cur or flag a hit
      OP_APPEND_NODE, // write the new node at the next free entry
      OP_APPEND_LINK, // hang the new node under last, z <= new node
      OP_RD_Z,        // read z
      OP_RD_P,        // hold parent of z, read it
      OP_RD_G,        // hold links of p, read grandparent
      OP_RD_U,        // pick the uncle from g, read it
      OP_SELECT,      // black uncle: choose rotation pivot and direction
      OP_RECOLOR_P,   // blacken p
      OP_RECOLOR_U,   // blacken uncle
      OP_RECOLOR_G,   // redden g, z <= g
      OP_ROT_RD_X,    // read pivot x
      OP_ROT_RD_Y,    // hold child y and upper node, read y
      OP_ROT_RD_UP,   // hold inner child of y, read upper node
      OP_ROT_WR1,     // relink x to the inner child, x under y
      OP_ROT_WR2,     // inner child under x, x below y
      OP_ROT_WR3,     // y under the upper node or as root
      OP_ROOT_BLACK   // blacken root
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic hit;        // key matched during descent
      logic at_nil;     // descent finished
      logic full;       // table holds NODES nodes
      logic z_root;     // z is the root
      logic p_black;    // parent of z is black
      logic uncle_red;
      logic rot_outer;  // rotation in progress is the closing one
   } stat_type;

endpackage
`default_nettype wire

/* hdl/rbt_datapath.sv */
`default_nettype none
module rbt_datapath
   import rbt_pkg::*;
#(
   parameter int NODES    = 1024,
   parameter int KEY_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   input  wire logic [KEY_BITS-1:0] key_in,
   input  wire logic                load_key,
   output      stat_type            stat,
   output      logic [$clog2(NODES + 1)-1:0] count
);

   localparam int IW = $clog2(NODES + 1);
   localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam logic [IW-1:0] NIL = IW'(NODES);

   logic [KEY_BITS-1:0] mem_key [NODES];
   logic [IW-1:0] mem_l [NODES];
   logic [IW-1:0] mem_r [NODES];
   logic [IW-1:0] mem_p [NODES];
   logic          mem_b [NODES];

   logic [KEY_BITS-1:0] key_ff;
   logic [IW-1:0] count_ff, cur_ff, last_ff, root_ff;
   logic go_left_ff, hit_ff;
   // rebalance registers: z, p, g, uncle and the links of p
   logic [IW-1:0] z_ff, p_ff, g_ff, u_ff, pl_ff, pr_ff;
   logic          side_ff;
   // rotation registers
   logic          to_left_ff, outer_ff, up_left_ff;
   logic [IW-1:0] x_ff, y_ff, b_ff, up_ff;
   // single read port result
   logic [KEY_BITS-1:0] rk_ff;
   logic [IW-1:0] rl_ff, rr_ff, rp_ff;
   logic          rb_ff;
   logic [IW-1:0] raddr, u_c, y_c;
   logic          key_eq, key_less, uncle_red, inner;

   function automatic logic [AW-1:0] ix(input logic [IW-1:0] v);
      return v[AW-1:0];
   endfunction

   function automatic logic lt_s(input logic [KEY_BITS-1:0] a, input logic [KEY_BITS-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

   assign key_eq    = (rk_ff == key_ff);
   assign key_less  = lt_s(key_ff, rk_ff);
   assign u_c       = (p_ff == rl_ff) ? rr_ff : rl_ff;
   assign y_c       = to_left_ff ? rr_ff : rl_ff;
   assign uncle_red = (u_ff != NIL) && !rb_ff;
   assign inner     = side_ff ? (z_ff == pr_ff) : (z_ff == pl_ff);

   always_comb begin
      unique case (cmd.op)
         OP_RD_CUR:    raddr = cur_ff;
         OP_RD_Z:      raddr = z_ff;
         OP_RD_P:      raddr = rp_ff;
         OP_RD_G:      raddr = rp_ff;
         OP_RD_U:      raddr = u_c;
         OP_ROT_RD_X:  raddr = x_ff;
         OP_ROT_RD_Y:  raddr = y_c;
         OP_ROT_RD_UP: raddr = up_ff;
         default:      raddr = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rk_ff <= mem_key[ix(raddr)];
      rl_ff <= mem_l[ix(raddr)];
      rr_ff <= mem_r[ix(raddr)];
      rp_ff <= mem_p[ix(raddr)];
      rb_ff <= mem_b[ix(raddr)];
   end

   // node table writes, at most one per field array each cycle
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_APPEND_NODE: begin
            mem_key[ix(count_ff)] <= key_ff;
            mem_l[ix(count_ff)]   <= NIL;
            mem_r[ix(count_ff)]   <= NIL;
            mem_p[ix(count_ff)]   <= last_ff;
            mem_b[ix(count_ff)]   <= 1'b0;
         end
         OP_APPEND_LINK: begin
            if (last_ff != NIL) begin
               if (go_left_ff) mem_l[ix(last_ff)] <= count_ff;
               else            mem_r[ix(last_ff)] <= count_ff;
            end
         end
         OP_RECOLOR_P: mem_b[ix(p_ff)] <= 1'b1;
         OP_RECOLOR_U: mem_b[ix(u_ff)] <= 1'b1;
         OP_RECOLOR_G: mem_b[ix(g_ff)] <= 1'b0;
         OP_ROT_WR1: begin
            if (to_left_ff) mem_r[ix(x_ff)] <= b_ff;
            else            mem_l[ix(x_ff)] <= b_ff;
            mem_p[ix(x_ff)] <= y_ff;
            // closing rotation: y is the parent to blacken
            if (outer_ff) mem_b[ix(y_ff)] <= 1'b1;
         end
         OP_ROT_WR2: begin
            if (b_ff != NIL) mem_p[ix(b_ff)] <= x_ff;
            if (to_left_ff) mem_l[ix(y_ff)] <= x_ff;
            else            mem_r[ix(y_ff)] <= x_ff;
            if (outer_ff) mem_b[ix(x_ff)] <= 1'b0;
         end
         OP_ROT_WR3: begin
            mem_p[ix(y_ff)] <= up_ff;
            if (up_ff != NIL) begin
               if (up_left_ff) mem_l[ix(up_ff)] <= y_ff;
               else            mem_r[ix(up_ff)] <= y_ff;
            end
         end
         OP_ROOT_BLACK: mem_b[ix(root_ff)] <= 1'b1;
         default: ;
      endcase
   end

   // working registers
   always_ff @(posedge clock) begin
      if (load_key) begin
         key_ff  <= key_in;
         cur_ff  <= (count_ff == '0) ? NIL : root_ff;
         last_ff <= NIL;
         hit_ff  <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_STEP: begin
               hit_ff <= key_eq;
               if (!key_eq) begin
                  last_ff    <= cur_ff;
                  go_left_ff <= key_less;
                  cur_ff     <= key_less ? rl_ff : rr_ff;
               end
            end
            OP_APPEND_LINK: z_ff <= count_ff;
            OP_RD_P: p_ff <= rp_ff;
            OP_RD_G: begin
               // read data holds p
               pl_ff <= rl_ff;
               pr_ff <= rr_ff;
               g_ff  <= rp_ff;
            end
            OP_RD_U: begin
               // read data holds g
               side_ff <= (p_ff == rl_ff);
               u_ff    <= u_c;
            end
            OP_SELECT: begin
               // read data holds the uncle
               if (!uncle_red) begin
                  if (inner) begin
                     z_ff       <= p_ff;
                     x_ff       <= p_ff;
                     to_left_ff <= side_ff;
                     outer_ff   <= 1'b0;
                  end else begin
                     x_ff       <= g_ff;
                     to_left_ff <= !side_ff;
                     outer_ff   <= 1'b1;
                  end
               end
            end
            OP_RECOLOR_G: z_ff <= g_ff;
            OP_ROT_RD_Y: begin
               // read data holds x
               y_ff  <= y_c;
               up_ff <= rp_ff;
            end
            OP_ROT_RD_UP: begin
               // read data holds y
               b_ff <= to_left_ff ? rl_ff : rr_ff;
            end
            OP_ROT_WR1: begin
               // read data holds the upper node
               up_left_ff <= (rl_ff == x_ff);
            end
            OP_ROT_WR3: begin
               if (!outer_ff) begin
                  x_ff       <= g_ff;
                  to_left_ff <= !to_left_ff;
                  outer_ff   <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // control registers with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         root_ff  <= '0;
      end else begin
         unique case (cmd.op)
            OP_APPEND_LINK: begin
               count_ff <= count_ff + 1'b1;
               if (last_ff == NIL) root_ff <= count_ff;
            end
            OP_ROT_WR3: begin
               if (up_ff == NIL) root_ff <= y_ff;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      stat.hit       = hit_ff;
      stat.at_nil    = (cur_ff == NIL) || hit_ff;
      stat.full      = (count_ff >= IW'(NODES));
      stat.z_root    = (z_ff == root_ff);
      stat.p_black   = rb_ff;
      stat.uncle_red = uncle_red;
      stat.rot_outer = outer_ff;
   end

   assign count = count_ff;

endmodule
`default_nettype wire

/* hdl/rbt_control.sv */
`default_nettype none
module rbt_control
   import rbt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_ready,
   input  wire logic     req_cmd,
   output      logic     load_key,
   output      cmd_type  cmd,
   input  wire stat_type stat,
   output      logic     rsp_valid,
   input  wire logic     rsp_ready,
   output      logic [1:0] rsp_status,
   output      logic     rsp_found
);

   typedef enum logic [4:0] {
      S_IDLE, S_DESC, S_RD, S_STEP, S_APP_NODE, S_APP_LINK, S_LOOP, S_RDZ, S_RDP,
      S_RDG, S_RDU, S_SEL, S_RC_P, S_RC_U, S_RC_G, S_RX, S_RY, S_RUP, S_W1, S_W2,
      S_W3, S_ROOT, S_RSP
   } state_type;

   state_type state_ff;
   logic      cmd_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign load_key  = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_RSP);

   always_comb begin
      unique case (state_ff)
         S_RD:       cmd.op = OP_RD_CUR;
         S_STEP:     cmd.op = OP_STEP;
         S_APP_NODE: cmd.op = OP_APPEND_NODE;
         S_APP_LINK: cmd.op = OP_APPEND_LINK;
         S_RDZ:      cmd.op = OP_RD_Z;
         S_RDP:      cmd.op = OP_RD_P;
         S_RDG:      cmd.op = OP_RD_G;
         S_RDU:      cmd.op = OP_RD_U;
         S_SEL:      cmd.op = OP_SELECT;
         S_RC_P:     cmd.op = OP_RECOLOR_P;
         S_RC_U:     cmd.op = OP_RECOLOR_U;
         S_RC_G:     cmd.op = OP_RECOLOR_G;
         S_RX:       cmd.op = OP_ROT_RD_X;
         S_RY:       cmd.op = OP_ROT_RD_Y;
         S_RUP:      cmd.op = OP_ROT_RD_UP;
         S_W1:       cmd.op = OP_ROT_WR1;
         S_W2:       cmd.op = OP_ROT_WR2;
         S_W3:       cmd.op = OP_ROT_WR3;
         S_ROOT:     cmd.op = OP_ROOT_BLACK;
         default:    cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmd_ff     <= CMD_INSERT;
         rsp_status <= ST_INSERTED;
         rsp_found  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (load_key) begin
               cmd_ff   <= req_cmd;
               state_ff <= S_DESC;
            end
            S_DESC: begin
               if (!stat.at_nil) begin
                  state_ff <= S_RD;
               end else begin
                  rsp_found <= (cmd_ff == CMD_QUERY) && stat.hit;
                  priority if (cmd_ff == CMD_QUERY) begin
                     rsp_status <= ST_QUERY;
                     state_ff   <= S_RSP;
                  end else if (stat.hit) begin
                     rsp_status <= ST_DUPLICATE;
                     state_ff   <= S_RSP;
                  end else if (stat.full) begin
                     rsp_status <= ST_FULL;
                     state_ff   <= S_RSP;
                  end else begin
                     rsp_status <= ST_INSERTED;
                     state_ff   <= S_APP_NODE;
                  end
               end
            end
            S_RD:       state_ff <= S_STEP;
            S_STEP:     state_ff <= S_DESC;
            S_APP_NODE: state_ff <= S_APP_LINK;
            S_APP_LINK: state_ff <= S_LOOP;
            S_LOOP:     state_ff <= stat.z_root ? S_ROOT : S_RDZ;
            S_RDZ:      state_ff <= S_RDP;
            S_RDP:      state_ff <= S_RDG;
            S_RDG:      state_ff <= stat.p_black ? S_ROOT : S_RDU;
            S_RDU:      state_ff <= S_SEL;
            S_SEL:      state_ff <= stat.uncle_red ? S_RC_P : S_RX;
            S_RC_P:     state_ff <= S_RC_U;
            S_RC_U:     state_ff <= S_RC_G;
            S_RC_G:     state_ff <= S_LOOP;
            S_RX:       state_ff <= S_RY;
            S_RY:       state_ff <= S_RUP;
            S_RUP:      state_ff <= S_W1;
            S_W1:       state_ff <= S_W2;
            S_W2:       state_ff <= S_W3;
            S_W3:       state_ff <= stat.rot_outer ? S_ROOT : S_RX;
            S_ROOT:     state_ff <= S_RSP;
            S_RSP:      if (rsp_ready) state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* hdl/red_black_tree_set.sv */
`default_nettype none
// Red-black tree set: insert or query one signed key per word.
// Steps: the descent reads and compares the nodes on the way down, then the result word follows;
// an insert adds the append, a recolor pass per recolored level, then a closing rotation, with
// an inner rotation before it where needed, or the end of the walk, all through the single table read port.
// Throughput: one word in flight; the next word is taken the cycle after the result leaves.
// Reset: synchronous active high; clears node count and root, table contents stay.
module red_black_tree_set
   import rbt_pkg::*;
#(
   parameter int NODES    = 1024,
   parameter int KEY_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_cmd,
   input  wire logic [KEY_BITS-1:0] req_key,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [1:0]          rsp_status,
   output      logic                rsp_found,
   output      logic [10:0]         rsp_node_count
);

   localparam int IW = $clog2(NODES + 1);

   cmd_type       cmd;
   stat_type      stat;
   logic          load_key;
   logic [IW-1:0] count;

   rbt_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .load_key,
      .cmd, .stat, .rsp_valid, .rsp_ready, .rsp_status, .rsp_found
   );

   rbt_datapath #(.NODES(NODES), .KEY_BITS(KEY_BITS)) u_dp (
      .clock, .reset, .cmd, .key_in(req_key), .load_key, .stat, .count
   );

   // node count reported with the result word
   assign rsp_node_count = 11'(count);

endmodule
`default_nettype wire

/* tb/rbt_checker.sv */
`timescale 1ns / 1ps
module rbt_checker
   import rbt_pkg::*;
#(
   parameter int NODES    = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_cmd,
   input  logic [KEY_BITS-1:0] req_key,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [1:0]          rsp_status,
   input  logic                rsp_found,
   input  logic [10:0]         rsp_node_count,
   output int                  fail_count,
   output int                  pending
);
   localparam int NIL = NODES;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [10:0] count;
   } answer_type;

   logic signed [KEY_BITS-1:0] t_key [NODES];
   int t_left [NODES];
   int t_right [NODES];
   int t_up [NODES];
   bit t_black [NODES];
   int n_nodes;
   int root;
   answer_type answers[$];

   function automatic bit red(int n);
      return n != NIL && !t_black[n];
   endfunction

   function automatic void relink(int old, int fresh);
      int up;
      up = t_up[old];
      t_up[fresh] = up;
      if (up == NIL) root = fresh;
      else if (t_left[up] == old) t_left[up] = fresh;
      else t_right[up] = fresh;
   endfunction

   function automatic void rotate(int x, bit to_left);
      int y;
      if (to_left) begin
         y = t_right[x];
         t_right[x] = t_left[y];
         if (t_left[y] != NIL) t_up[t_left[y]] = x;
         relink(x, y);
         t_left[y] = x;
      end else begin
         y = t_left[x];
         t_left[x] = t_right[y];
         if (t_right[y] != NIL) t_up[t_right[y]] = x;
         relink(x, y);
         t_right[y] = x;
      end
      t_up[x] = y;
   endfunction

   function automatic void fix_up(int z);
      int p, g, u;
      bit pl;
      while (z != root && red(t_up[z])) begin
         p = t_up[z];
         g = t_up[p];
         pl = (p == t_left[g]);
         u = pl ? t_right[g] : t_left[g];
         if (red(u)) begin
            t_black[p] = 1;
            t_black[u] = 1;
            t_black[g] = 0;
            z = g;
         end else begin
            if (pl ? (z == t_right[p]) : (z == t_left[p])) begin
               z = p;
               rotate(z, pl);
               p = t_up[z];
            end
            t_black[p] = 1;
            t_black[g] = 0;
            rotate(g, !pl);
         end
      end
      t_black[root] = 1;
   endfunction

   function automatic answer_type apply_word(logic cmd, logic signed [KEY_BITS-1:0] k);
      answer_type a;
      int cur, last;
      bit hit, go_left;
      cur = (n_nodes == 0) ? NIL : root;
      last = NIL;
      hit = 0;
      go_left = 0;
      while (cur != NIL) begin
         if (k == t_key[cur]) begin
            hit = 1;
            break;
         end
         last = cur;
         go_left = k < t_key[cur];
         cur = go_left ? t_left[cur] : t_right[cur];
      end
      a.found = 0;
      if (cmd == CMD_QUERY) begin
         a.status = ST_QUERY;
         a.found = hit;
      end else if (hit) a.status = ST_DUPLICATE;
      else if (n_nodes >= NODES) a.status = ST_FULL;
      else begin
         t_key[n_nodes] = k;
         t_left[n_nodes] = NIL;
         t_right[n_nodes] = NIL;
         t_up[n_nodes] = last;
         t_black[n_nodes] = 0;
         if (last == NIL) root = n_nodes;
         else if (go_left) t_left[last] = n_nodes;
         else t_right[last] = n_nodes;
         n_nodes++;
         fix_up(n_nodes - 1);
         a.status = ST_INSERTED;
      end
      a.count = 11'(n_nodes);
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         n_nodes = 0;
         root = 0;
         fail_count = 0;
         answers.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word: status %0d found %0d count %0d",
                           rsp_status, rsp_found, rsp_node_count);
            end else begin
               want = answers.pop_front();
               if (want.status !== rsp_status || want.found !== rsp_found ||
                   want.count !== rsp_node_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                              want.status, want.found, want.count,
                              rsp_status, rsp_found, rsp_node_count);
               end
            end
         end
         // predict after the pop so a same-edge result cannot match the new word
         if (req_valid && req_ready)
            answers = {answers, apply_word(req_cmd, req_key)};
      end
   end

   assign pending = answers.size();
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import rbt_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_cmd = CMD_INSERT;
   logic [31:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic        rsp_found;
   logic [10:0] rsp_node_count;
   int          fail_count;
   int          pending;

   int send_idle_pct = 29;
   int recv_idle_pct = 52;
   bit recv_hold = 0;
   logic [31:0] used_keys[$];

   red_black_tree_set u_dut (.*);

   rbt_checker u_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off while recv_hold is set
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // offer one word, idle at random first, hold until accepted
   task automatic send_word(logic cmd, logic [31:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_key <= k;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // pick a key: reuse an earlier one in 40 percent of picks so duplicates and hits happen
   function automatic logic [31:0] pick_key();
      logic [31:0] k;
      if (used_keys.size() > 0 && $urandom_range(99) < 40)
         k = used_keys[$urandom_range(used_keys.size() - 1)];
      else begin
         case ($urandom_range(3))
            0: k = $urandom;
            1: k = $urandom_range(40);
            2: k = -$urandom_range(40);
            default: k = {1'($urandom_range(1)), 31'($urandom)};
         endcase
      end
      return k;
   endfunction

   // stop offering, then wait until every expected result has come
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] k;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: query empty tree, key extremes, duplicates, ordered runs
      send_word(CMD_QUERY, 32'h0);
      send_word(CMD_QUERY, 32'h8000_0000);
      send_word(CMD_INSERT, 32'h8000_0000);
      send_word(CMD_INSERT, 32'h7fff_ffff);
      send_word(CMD_INSERT, 32'hffff_ffff);
      send_word(CMD_INSERT, 32'h0);
      send_word(CMD_INSERT, 32'h8000_0000);
      send_word(CMD_QUERY, 32'h7fff_ffff);
      send_word(CMD_QUERY, 32'h0000_0001);
      for (int i = 1; i <= 6; i++) send_word(CMD_INSERT, 32'(i));
      for (int i = 1; i <= 6; i++) send_word(CMD_INSERT, -32'(i * 10));
      send_word(CMD_QUERY, -32'd30);
      send_word(CMD_QUERY, 32'h5555_aaaa);
      drain();

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            recv_hold = 1;
            repeat (400) @(posedge clock);
            recv_hold = 0;
         end
         for (int i = 0; i < 8; i++) send_word(CMD_INSERT, 32'(100 + i));
      join
      drain();

      // random phases with swapped then no idling
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 52 : 0;
         recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 29 : 0;
         for (int i = 0; i < 230; i++) begin
            k = pick_key();
            used_keys = {used_keys, k};
            send_word($urandom_range(99) < 35 ? CMD_QUERY : CMD_INSERT, k);
         end
         drain();
      end

      // closing queries on the grown tree
      for (int i = 0; i < 20; i++) send_word(CMD_QUERY, pick_key());
      drain();
      repeat (200) @(posedge clock);

      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end
endmodule
